/* rtl/bounded_set_sorted_dump_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the bounded set sorted dump unit.
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SORTED_DUMP_UNIT_DEFINES_SVH
`define BOUNDED_SET_SORTED_DUMP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BSSD_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BSSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bssd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssd_pkg
// Types and constants shared by the bounded set sorted dump unit.
// ----------------------------------------------------------------------------
package bssd_pkg;

	localparam int DATA_W       = 32;
	localparam int CNT_W        = 5;
	localparam int MODE_W       = 2;
	localparam int MAX_RESULTS  = 16;
	localparam int DEF_CAPACITY = 16;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

	// Register index (word address bit)
	localparam logic REG_CAPACITY_LIMIT = 1'b0;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // capture transaction value, restart dump pass count
		logic scan_clr;   // restart a scan over the stored entries
		logic scan_step;  // issue the next scan read
		logic dump_scan;  // scan looks for the next ascending value
		logic rd_last;    // read the last stored entry
		logic ram_we;     // write an entry
		logic wr_at_pos;  // write the read entry into the hit slot
		logic count_inc;
		logic count_dec;
		logic emit_entry; // present one sorted entry
		logic emit_empty; // present the empty-set result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic full;
		logic count_zero;
		logic scan_done;
		logic hit;
		logic last_pass;
	} dp_stat_t;

endpackage

/* rtl/bssd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bssd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/bssd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssd_ctrl
// Sequencer for insert, remove and sorted dump transactions.
// ----------------------------------------------------------------------------
module bssd_ctrl
	import bssd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MODE_W-1:0] mode,
	output logic              busy,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_REM_SCAN,
		ST_REM_MOVE,
		ST_DUMP_SCAN
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					case (mode)
						MODE_INSERT: begin
							if (!stat.full) state_d = ST_INS_SCAN;
						end
						MODE_REMOVE: state_d = ST_REM_SCAN;
						MODE_DUMP: begin
							if (stat.count_zero) cmd.emit_empty = 1'b1;
							else state_d = ST_DUMP_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					if (!stat.hit) begin
						cmd.ram_we    = 1'b1;
						cmd.count_inc = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_REM_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) begin
					if (stat.hit) begin
						cmd.rd_last = 1'b1;
						state_d     = ST_REM_MOVE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_REM_MOVE: begin
				// last entry fills the freed slot
				cmd.ram_we    = 1'b1;
				cmd.wr_at_pos = 1'b1;
				cmd.count_dec = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_DUMP_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.dump_scan = 1'b1;
				if (stat.scan_done) begin
					cmd.emit_entry = 1'b1;
					if (stat.last_pass) state_d = ST_IDLE;
					else cmd.scan_clr = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and registered busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

/* rtl/bssd_datapath.sv */
`timescale 1ns / 1ps
`include "bounded_set_sorted_dump_unit_defines.svh"
// ----------------------------------------------------------------------------
// bssd_datapath
// Entry store, scan pipeline, count, minimum search and result registers.
// ----------------------------------------------------------------------------
module bssd_datapath
	import bssd_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic signed [DATA_W-1:0] in_value,
	input  logic [CNT_W-1:0]         cap_limit,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] entry,
	output logic                     empty_flag,
	output logic                     last
);

	// No more entries than the result limit can ever be held
	localparam int EFF_DEPTH = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;
	localparam int AW        = (EFF_DEPTH > 1) ? $clog2(EFF_DEPTH) : 1;

	logic [CNT_W-1:0]         count_q, idx_q, k_q, lim;
	logic                     rd_vld_s1, hit_q, have_q, strobe_q;
	logic [AW-1:0]            rd_idx_s1, pos_q, raddr, waddr, last_idx;
	logic signed [DATA_W-1:0] value_q, best_q, prev_q, entry_q;
	logic signed [DATA_W-1:0] rdata_s;
	logic [DATA_W-1:0]        rdata, wdata;
	logic                     empty_q, last_q;
	logic                     issue, match, take;

	// Effective limit
	assign lim = (cap_limit > CNT_W'(EFF_DEPTH)) ? CNT_W'(EFF_DEPTH) : cap_limit;

	// Scan read issue and RAM addressing
	assign issue    = cmd.scan_step && (idx_q != count_q);
	assign last_idx = AW'(count_q - 1'b1);
	assign raddr    = cmd.rd_last ? last_idx : idx_q[AW-1:0];
	assign waddr    = cmd.wr_at_pos ? pos_q : count_q[AW-1:0];
	assign wdata    = cmd.wr_at_pos ? rdata : value_q;
	assign rdata_s  = rdata;

	bssd_ram #(
		.WIDTH (DATA_W),
		.DEPTH (EFF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (issue | cmd.rd_last),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Compare on returned read data
	assign match = rd_vld_s1 && !cmd.dump_scan && (rdata_s == value_q);
	assign take  = rd_vld_s1 && cmd.dump_scan &&
		((k_q == '0) || (rdata_s > prev_q)) &&
		(!have_q || (rdata_s < best_q));

	// Status
	assign stat.full       = (count_q >= lim);
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_done  = (idx_q == count_q) && !rd_vld_s1;
	assign stat.hit        = hit_q;
	assign stat.last_pass  = (k_q == CNT_W'(count_q - 1'b1));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			have_q    <= 1'b0;
			count_q   <= '0;
			k_q       <= '0;
			strobe_q  <= 1'b0;
		end else begin
			if (cmd.scan_clr) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
				have_q    <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) idx_q <= idx_q + 1'b1;
				if (match) hit_q <= 1'b1;
				if (take) have_q <= 1'b1;
			end
			if (cmd.count_inc) count_q <= count_q + 1'b1;
			else if (cmd.count_dec) count_q <= count_q - 1'b1;
			if (cmd.load) k_q <= '0;
			else if (cmd.emit_entry) k_q <= k_q + 1'b1;
			strobe_q <= cmd.emit_entry | cmd.emit_empty;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (cmd.load) value_q <= in_value;
		if (match) pos_q <= rd_idx_s1;
		if (take) best_q <= rdata_s;
		if (cmd.emit_entry) begin
			prev_q  <= best_q;
			entry_q <= best_q;
			empty_q <= 1'b0;
			last_q  <= stat.last_pass;
		end else if (cmd.emit_empty) begin
			entry_q <= '0;
			empty_q <= 1'b1;
			last_q  <= 1'b1;
		end
	end

	assign strobe     = strobe_q;
	assign entry      = entry_q;
	assign empty_flag = empty_q;
	assign last       = last_q;

	// Checks
	`BSSD_ASSERT(a_insert_room, cmd.count_inc, count_q < lim, "insert beyond limit")
	`BSSD_ASSERT_NEXT(a_count_inc, cmd.count_inc, count_q == $past(count_q) + 1'b1, "count step")
	`BSSD_ASSERT(a_dec_nonzero, cmd.count_dec, count_q != '0, "remove from empty set")
	`BSSD_ASSERT(a_dump_order, cmd.emit_entry && (k_q != '0), best_q > prev_q, "dump not ascending")
	`BSSD_ASSERT(a_dump_found, cmd.emit_entry, have_q, "dump pass found no entry")

endmodule

/* rtl/bounded_set_sorted_dump_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_sorted_dump_unit
// Bounded set of distinct signed 32-bit values with insert, remove and an
// ascending sorted dump; capacity limit set over an APB-style port.
//
// Channel   Signals                                   Handshake
// command   start, mode, value                        start & !busy
// result    strobe, entry, empty_flag, last           strobe, one cycle, no stall
// config    psel, penable, pwrite, paddr, pwdata,     psel & penable & pready
//           prdata, pready
//
// A scan reads the held entries in turn through the registered read port of
// the entry RAM. After the accepting cycle busy holds for one scan on an
// insert, one scan plus a move of the last entry on a remove hit, and one
// scan per held entry on a dump, one result per scan. A full insert, an empty
// dump and ignored codes raise no busy. Reset clears the count and the limit
// returns to 16; entry storage is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bounded_set_sorted_dump_unit
	import bssd_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] value,
	// result
	output logic                     strobe,
	output logic signed [DATA_W-1:0] entry,
	output logic                     empty_flag,
	output logic                     last,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [CNT_W-1:0] cap_q;
	logic             cfg_wr;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	// Capacity limit register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ? 32'(cap_q) : '0;

	bssd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	bssd_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_value   (value),
		.cap_limit  (cap_q),
		.strobe     (strobe),
		.entry      (entry),
		.empty_flag (empty_flag),
		.last       (last)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded set sorted dump unit. A queue of
// insert, remove, dump and unused-code commands feeds a driver with random
// idle bursts. A shadow copy of the set predicts every dump transaction, and
// the monitor compares each strobed result with the oldest prediction. The
// capacity limit is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module testbench;
	import bssd_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_CAPACITY = 3'd0;
	localparam logic [2:0] ADDR_SPARE    = 3'd4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_SETTLE = 40;
	localparam int DRAIN_CYCLES = 300;
	localparam int POOL_N       = 24;

	typedef struct {
		logic [MODE_W-1:0]        op;
		logic signed [DATA_W-1:0] val;
	} set_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] entry;
		logic                     empty_flag;
		logic                     last;
	} dump_item_t;

	// DUT signals
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [MODE_W-1:0]        mode = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     strobe;
	logic signed [DATA_W-1:0] entry;
	logic                     empty_flag;
	logic                     last;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [2:0]               paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;

	// Shadow set and expected dump results
	logic signed [DATA_W-1:0] held_vals [DEF_CAPACITY];
	int                       held_count = 0;
	logic [CNT_W-1:0]         cap_reg = CAP_RESET;
	dump_item_t               dump_expected [$];
	set_cmd_t                 cmd_queue [$];
	logic signed [DATA_W-1:0] pool [POOL_N];

	int errors = 0;
	int gap_left = 0;
	int cycle_count = 0;
	bit item_taken = 1'b0;
	bit calm = 1'b0;

	bounded_set_sorted_dump_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.value      (value),
		.strobe     (strobe),
		.entry      (entry),
		.empty_flag (empty_flag),
		.last       (last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_set_sorted_dump_unit: mismatch");
			$finish;
		end
	end

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s got %h, want %h", $time, field, got, want);
		errors++;
	endtask

	// Shadow set update for one accepted command; dumps queue their results
	task automatic set_apply(input set_cmd_t c);
		int lim;
		int pos;
		logic signed [DATA_W-1:0] t;
		lim = int'(cap_reg);
		if (lim > DEF_CAPACITY) lim = DEF_CAPACITY;
		if (lim > MAX_RESULTS) lim = MAX_RESULTS;
		pos = -1;
		for (int i = 0; i < held_count; i++)
			if (pos < 0 && held_vals[i] == c.val) pos = i;
		case (c.op)
			MODE_INSERT: begin
				if (held_count < lim && pos < 0) begin
					held_vals[held_count] = c.val;
					held_count++;
				end
			end
			MODE_REMOVE: begin
				if (pos >= 0) begin
					for (int i = pos; i + 1 < held_count; i++)
						held_vals[i] = held_vals[i + 1];
					held_count--;
				end
			end
			MODE_DUMP: begin
				if (held_count == 0) begin
					dump_expected.push_back('{entry: '0, empty_flag: 1'b1, last: 1'b1});
				end else begin
					// ascending signed order, kept in place
					for (int i = 0; i < held_count; i++)
						for (int j = i + 1; j < held_count; j++)
							if (held_vals[i] > held_vals[j]) begin
								t = held_vals[i];
								held_vals[i] = held_vals[j];
								held_vals[j] = t;
							end
					for (int i = 0; i < held_count; i++)
						dump_expected.push_back('{entry: held_vals[i], empty_flag: 1'b0,
							last: (i == held_count - 1)});
				end
			end
			default: ;
		endcase
	endtask

	// Monitor: check results, then take in the command and register writes
	always @(posedge clk) begin
		dump_item_t want;
		set_cmd_t c;
		if (arst_n) begin
			if (strobe) begin
				if (dump_expected.size() == 0) begin
					report("unexpected result, entry", entry, '0);
				end else begin
					want = dump_expected.pop_front();
					if (entry !== want.entry) report("entry", entry, want.entry);
					if (empty_flag !== want.empty_flag)
						report("empty_flag", 32'(empty_flag), 32'(want.empty_flag));
					if (last !== want.last) report("last", 32'(last), 32'(want.last));
				end
			end
			item_taken = start && !busy;
			if (item_taken) begin
				c.op = mode;
				c.val = value;
				set_apply(c);
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY_LIMIT)
				cap_reg = pwdata[CNT_W-1:0];
		end
	end

	// Driver: one command per transaction, random idle bursts between them
	always @(negedge clk) begin
		set_cmd_t c;
		if (arst_n && (!start || item_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cmd_queue.size() > 0) begin
				c = cmd_queue.pop_front();
				start <= 1'b1;
				mode <= c.op;
				value <= c.val;
				if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic push_cmd(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] val);
		set_cmd_t c;
		c.op = op;
		c.val = val;
		cmd_queue.push_back(c);
	endtask

	// Hold the sender until everything has drained and the block is idle
	task automatic settle(input int extra);
		while (cmd_queue.size() != 0 || start || dump_expected.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Capacity write with random junk above the register bits
	task automatic set_capacity(input logic [4:0] cap);
		settle(PHASE_SETTLE);
		reg_write(ADDR_CAPACITY, ($urandom() & 32'hFFFF_FFE0) | 32'(cap));
	endtask

	task automatic random_phase(input int n);
		int r;
		logic [DATA_W-1:0] v;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_N - 1)] : $urandom();
			if (r < 45) push_cmd(MODE_INSERT, v);
			else if (r < 75) push_cmd(MODE_REMOVE, v);
			else if (r < 94) push_cmd(MODE_DUMP, v);
			else push_cmd(MODE_UNUSED, v);
		end
	endtask

	// Stimulus
	initial begin
		pool[0] = 32'sh7FFF_FFFF;
		pool[1] = 32'sh8000_0000;
		pool[2] = 32'sh0000_0000;
		pool[3] = 32'shFFFF_FFFF;
		pool[4] = 32'sh0000_0001;
		for (int i = 5; i < POOL_N; i++) pool[i] = $urandom();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty dump, extremes, duplicate, absent remove, unused code
		push_cmd(MODE_DUMP, $urandom());
		for (int i = 0; i < 5; i++) push_cmd(MODE_INSERT, pool[i]);
		push_cmd(MODE_INSERT, pool[0]);
		push_cmd(MODE_REMOVE, 32'sh0000_3039);
		push_cmd(MODE_UNUSED, $urandom());
		push_cmd(MODE_REMOVE, pool[1]);
		push_cmd(MODE_DUMP, $urandom());
		// fill to capacity, one insert past full, full-size dump
		for (int i = 5; i < 17; i++) push_cmd(MODE_INSERT, pool[i]);
		push_cmd(MODE_INSERT, pool[17]);
		push_cmd(MODE_DUMP, $urandom());

		// limit lowered below the current count
		set_capacity(5'd3);
		push_cmd(MODE_INSERT, pool[18]);
		push_cmd(MODE_REMOVE, pool[5]);
		push_cmd(MODE_DUMP, $urandom());

		// random phases over several limits, zero and out-of-range among them
		set_capacity(5'd16);
		random_phase(12);
		set_capacity(5'd0);
		random_phase(12);
		settle(PHASE_SETTLE);
		reg_write(ADDR_SPARE, $urandom());
		set_capacity(5'd5);
		random_phase(12);
		set_capacity(5'd1);
		random_phase(12);
		set_capacity(5'd31);
		random_phase(12);
		set_capacity(5'($urandom_range(2, 15)));
		random_phase(12);
		set_capacity(5'd16);
		calm = 1'b1;
		random_phase(12);

		settle(DRAIN_CYCLES);
		if (errors == 0) begin
			$display("bounded_set_sorted_dump_unit: match");
		end else begin
			$display("bounded_set_sorted_dump_unit: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/bssd_pkg.sv
rtl/bssd_ram.sv
rtl/bssd_ctrl.sv
rtl/bssd_datapath.sv
rtl/bounded_set_sorted_dump_unit.sv
tb/testbench.sv
